[rtl/core/depth_pixel_to_point_unit_macros.svh]
// Assertion macros shared by the depth_pixel_to_point_unit RTL.
// Define NO_ASSERTIONS to compile them out; the users need clk_i and rst_ni in scope.
`ifndef DEPTH_PIXEL_TO_POINT_UNIT_MACROS_SVH
`define DEPTH_PIXEL_TO_POINT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define D2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked at every edge, reset included
`define D2P_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define D2P_ASSERT(lbl, prop, msg)
`define D2P_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/core/d2p_pkg.sv]
// Package for the depth pixel to point unit: register codes, widths and the
// axis stage control struct. No dependencies.
package d2p_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROW_START   = 3'd0,
    CFG_ROW_END     = 3'd1,
    CFG_COL_START   = 3'd2,
    CFG_COL_END     = 3'd3,
    CFG_CENTER_X    = 3'd4,
    CFG_CENTER_Y    = 3'd5,
    CFG_INV_FOCAL_X = 3'd6,
    CFG_INV_FOCAL_Y = 3'd7
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Valid depth range [DEPTH_MIN, DEPTH_MAX)
  localparam logic [15:0] DEPTH_MIN = 16'd100;
  localparam logic [15:0] DEPTH_MAX = 16'd2500;

  // Datapath widths
  localparam int unsigned Z_W   = 28;  // depth in Q12.16, kept depths only
  localparam int unsigned MAG_W = 16;  // magnitude of the Q12.4 offset
  localparam int unsigned INV_W = 32;  // reciprocal focal length, Q0.32
  localparam int unsigned POS_W = 32;  // signed Q16.16 output

  // Stage enables of the projection pipeline of one axis
  typedef struct packed {
    logic mul_en;   // offset times depth
    logic part_en;  // partial products with the reciprocal
    logic rnd_en;   // sum and round
    logic sat_en;   // sign and saturate
  } axis_ctrl_t;

endpackage

[rtl/core/d2p_axis.sv]
// One axis of the back-projection: round(offset * z * inv / 2^36), saturated.
// Four pipeline stages driven by d2p_pkg::axis_ctrl_t enables; uses d2p_pkg.
module d2p_axis (
  input  logic                               clk_i,
  input  d2p_pkg::axis_ctrl_t                ctrl_i,
  input  logic                               neg_i,
  input  logic [d2p_pkg::MAG_W-1:0]          mag_i,
  input  logic [d2p_pkg::Z_W-1:0]            z_i,
  input  logic [d2p_pkg::INV_W-1:0]          inv_i,
  output logic signed [d2p_pkg::POS_W-1:0]   pos_o
);

  localparam int unsigned M_W   = d2p_pkg::MAG_W + d2p_pkg::Z_W;  // 44
  localparam int unsigned P_W   = M_W + 16;                       // 60
  localparam int unsigned S_W   = P_W + 1;                        // 61
  localparam int unsigned R_W   = S_W - 20;                       // 41
  localparam logic [S_W-1:0] ROUND_HALF = S_W'(1) << 19;
  localparam logic [R_W-1:0] POS_LIMIT  = R_W'(32'h7FFF_FFFF);
  localparam logic [R_W-1:0] NEG_LIMIT  = R_W'(1) << 31;

  logic [M_W-1:0] m_q, m_d;
  logic [P_W-1:0] plo_q, plo_d, phi_q, phi_d;
  logic [S_W-1:0] sum;
  logic [R_W-1:0] r_q, r_d;
  logic [d2p_pkg::POS_W-1:0] pos_q, pos_d;
  logic neg5_q, neg6_q, neg7_q;

  // Stage 5: offset magnitude times depth
  assign m_d = M_W'(mag_i) * M_W'(z_i);

  // Stage 6: two 44x16 partial products
  assign plo_d = P_W'(m_q) * P_W'(inv_i[15:0]);
  assign phi_d = P_W'(m_q) * P_W'(inv_i[31:16]);

  // Stage 7: combine and round half up on the magnitude
  assign sum = S_W'(phi_q) + S_W'(plo_q >> 16) + ROUND_HALF;
  assign r_d = sum[S_W-1:20];

  // Stage 8: apply sign with saturation
  always_comb begin
    if (neg7_q) begin
      if (r_q >= NEG_LIMIT) begin
        pos_d = 32'h8000_0000;
      end else begin
        pos_d = ~r_q[31:0] + 32'd1;
      end
    end else begin
      if (r_q > POS_LIMIT) begin
        pos_d = 32'h7FFF_FFFF;
      end else begin
        pos_d = r_q[31:0];
      end
    end
  end

  // Payload registers, advanced by the stage enables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      m_q    <= m_d;
      neg5_q <= neg_i;
    end
    if (ctrl_i.part_en) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      neg6_q <= neg5_q;
    end
    if (ctrl_i.rnd_en) begin
      r_q    <= r_d;
      neg7_q <= neg6_q;
    end
    if (ctrl_i.sat_en) begin
      pos_q  <= pos_d;
    end
  end

  assign pos_o = signed'(pos_q);

endmodule

[rtl/core/depth_pixel_to_point_unit.sv]
// Depth pixel to point unit: window and depth filter, z division by a
// constant, pinhole back-projection of x and y. Uses d2p_pkg, d2p_axis.
//
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   one register per item; it is always ready. Write it only while idle.
//   Pixel items enter on in_valid_i/in_ready_o, one point leaves on
//   out_valid_o/out_ready_i for every pixel inside the window with depth in
//   [100, 2500); other pixels are dropped at the first stage.
//   An accepted item passes the 8-stage pipeline, one register per stage, to
//   the output. Throughput is one item per cycle while out_ready_i is high.
//   Each stage has its own valid bit and loads when empty or when the stage
//   after it moves, so bubbles close up. When the receiver stalls the output
//   holds, and in_ready_o falls only once every stage holds an item.
//   Reset clears all valid bits and loads the default window, principal
//   point and reciprocal focal lengths.
module depth_pixel_to_point_unit #(
  parameter int unsigned DEPTH_FACTOR = 1000,
  parameter int unsigned MAX_DIM      = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [d2p_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [d2p_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [11:0]                          row_i,
  input  logic [11:0]                          col_i,
  input  logic [15:0]                          depth_i,
  input  logic [7:0]                           blue_i,
  input  logic [7:0]                           green_i,
  input  logic [7:0]                           red_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   pos_x_o,
  output logic signed [31:0]                   pos_y_o,
  output logic [30:0]                          pos_z_o,
  output logic [7:0]                           out_red_o,
  output logic [7:0]                           out_green_o,
  output logic [7:0]                           out_blue_o
);

  localparam int unsigned ZW = d2p_pkg::Z_W;
  localparam int unsigned NS = 8;  // pipeline stages

  localparam int unsigned DIM_RESET = (MAX_DIM > 4096) ? 4096 : MAX_DIM;
  localparam logic [12:0] END_RESET = 13'(DIM_RESET);
  localparam logic [16:0] DIM_LIMIT = 17'(MAX_DIM);
  localparam int unsigned HALF_FACTOR = DEPTH_FACTOR / 2;
  localparam logic [ZW:0] RECIP = (ZW+1)'((64'd1 << ZW) / DEPTH_FACTOR);
  localparam logic [15:0] FACTOR = 16'(DEPTH_FACTOR);
  localparam logic [ZW:0] REM_LIMIT = (ZW+1)'(2 * DEPTH_FACTOR);
  localparam logic [30:0] Z_LIMIT =
    31'(((64'd2499 << 16) + 64'(HALF_FACTOR)) / DEPTH_FACTOR);

  typedef struct packed {
    logic        neg_x;
    logic [15:0] mag_x;
    logic        neg_y;
    logic [15:0] mag_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } side_t;

  // Configuration registers
  logic [11:0] row_start_q, col_start_q;
  logic [12:0] row_end_q, col_end_q;
  logic [15:0] center_x_q, center_y_q;
  logic [31:0] inv_focal_x_q, inv_focal_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_start_q   <= '0;
      row_end_q     <= END_RESET;
      col_start_q   <= '0;
      col_end_q     <= END_RESET;
      center_x_q    <= 16'd5120;
      center_y_q    <= 16'd3840;
      inv_focal_x_q <= 32'd8589934;
      inv_focal_y_q <= 32'd8589934;
    end else if (cfg_valid_i) begin
      case (d2p_pkg::cfg_reg_e'(cfg_index_i))
        d2p_pkg::CFG_ROW_START:   row_start_q   <= cfg_data_i[11:0];
        d2p_pkg::CFG_ROW_END:     row_end_q     <= cfg_data_i[12:0];
        d2p_pkg::CFG_COL_START:   col_start_q   <= cfg_data_i[11:0];
        d2p_pkg::CFG_COL_END:     col_end_q     <= cfg_data_i[12:0];
        d2p_pkg::CFG_CENTER_X:    center_x_q    <= cfg_data_i[15:0];
        d2p_pkg::CFG_CENTER_Y:    center_y_q    <= cfg_data_i[15:0];
        d2p_pkg::CFG_INV_FOCAL_X: inv_focal_x_q <= cfg_data_i;
        d2p_pkg::CFG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NS:1]   v_q, v_d;
  logic [NS+1:1] adv;

  always_comb begin
    adv[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[1];

  // Stage 1 logic: window, depth filter, numerator and offsets
  logic        keep, row_ok, col_ok, depth_ok;
  logic [ZW-1:0] num_d;
  logic [16:0] diff_x, diff_y;
  side_t       side_d;

  always_comb begin
    row_ok = (row_i >= row_start_q) && ({1'b0, row_i} < row_end_q)
             && ({5'b0, row_i} < DIM_LIMIT);
    col_ok = (col_i >= col_start_q) && ({1'b0, col_i} < col_end_q)
             && ({5'b0, col_i} < DIM_LIMIT);
    depth_ok = (depth_i >= d2p_pkg::DEPTH_MIN) && (depth_i < d2p_pkg::DEPTH_MAX);
    keep = row_ok && col_ok && depth_ok;
    // kept depths are below 4096, so 12 bits of depth are enough
    num_d = {depth_i[11:0], 16'b0} + ZW'(HALF_FACTOR);
    diff_x = {1'b0, col_i, 4'b0} - {1'b0, center_x_q};
    diff_y = {1'b0, row_i, 4'b0} - {1'b0, center_y_q};
    side_d.neg_x = diff_x[16];
    side_d.mag_x = diff_x[16] ? (~diff_x[15:0] + 16'd1) : diff_x[15:0];
    side_d.neg_y = diff_y[16];
    side_d.mag_y = diff_y[16] ? (~diff_y[15:0] + 16'd1) : diff_y[15:0];
    side_d.red   = red_i;
    side_d.green = green_i;
    side_d.blue  = blue_i;
  end

  always_comb begin
    v_d[1] = in_valid_i && keep;
    for (int k = 2; k <= NS; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) v_q[k] <= v_d[k];
      end
    end
  end

  // Side data shift line travels with the valid bits
  side_t side_q [1:NS];

  always_ff @(posedge clk_i) begin
    if (adv[1]) side_q[1] <= side_d;
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) side_q[k] <= side_q[k-1];
    end
  end

  // Stages 2..4: z = floor(num / DEPTH_FACTOR) by reciprocal and one correction
  logic [ZW-1:0] num1_q, num2_q, num3_q;
  logic [ZW-1:0] q0_d, q2_q, q3_q, fac_d, fac3_q, rem, z_d;
  logic [2*ZW:0] qmul;
  logic [ZW+15:0] fmul;

  assign qmul  = (2*ZW+1)'(num1_q) * (2*ZW+1)'(RECIP);
  assign q0_d  = qmul[2*ZW-1:ZW];
  assign fmul  = (ZW+16)'(q2_q) * (ZW+16)'(FACTOR);
  assign fac_d = fmul[ZW-1:0];  // never exceeds the numerator
  assign rem   = num3_q - fac3_q;
  assign z_d   = q3_q + ZW'(rem >= ZW'(FACTOR));

  // z shift line for stages 4..8
  logic [ZW-1:0] z_q [4:NS];

  always_ff @(posedge clk_i) begin
    if (adv[1]) num1_q <= num_d;
    if (adv[2]) begin
      q2_q   <= q0_d;
      num2_q <= num1_q;
    end
    if (adv[3]) begin
      fac3_q <= fac_d;
      q3_q   <= q2_q;
      num3_q <= num2_q;
    end
    if (adv[4]) z_q[4] <= z_d;
    for (int k = 5; k <= NS; k++) begin
      if (adv[k]) z_q[k] <= z_q[k-1];
    end
  end

  // Stages 5..8: x and y projection
  d2p_pkg::axis_ctrl_t axis_ctrl;

  assign axis_ctrl.mul_en  = adv[5];
  assign axis_ctrl.part_en = adv[6];
  assign axis_ctrl.rnd_en  = adv[7];
  assign axis_ctrl.sat_en  = adv[8];

  d2p_axis u_axis_x (
    .clk_i  (clk_i),
    .ctrl_i (axis_ctrl),
    .neg_i  (side_q[4].neg_x),
    .mag_i  (side_q[4].mag_x),
    .z_i    (z_q[4]),
    .inv_i  (inv_focal_x_q),
    .pos_o  (pos_x_o)
  );

  d2p_axis u_axis_y (
    .clk_i  (clk_i),
    .ctrl_i (axis_ctrl),
    .neg_i  (side_q[4].neg_y),
    .mag_i  (side_q[4].mag_y),
    .z_i    (z_q[4]),
    .inv_i  (inv_focal_y_q),
    .pos_o  (pos_y_o)
  );

  // Output stage
  assign out_valid_o = v_q[NS];
  assign pos_z_o     = 31'(z_q[NS]);
  assign out_red_o   = side_q[NS].red;
  assign out_green_o = side_q[NS].green;
  assign out_blue_o  = side_q[NS].blue;

  // Assertions
  `include "depth_pixel_to_point_unit_macros.svh"

  `D2P_ASSERT(a_full_stall_blocks_input,
    (&v_q) && !out_ready_i |-> !in_ready_o,
    "input accepted while every stage is full and output stalled")
  `D2P_ASSERT(a_shallow_depth_dropped,
    in_valid_i && in_ready_o && (depth_i < d2p_pkg::DEPTH_MIN) |=> !v_q[1],
    "pixel with depth below minimum entered the pipeline")
  `D2P_ASSERT(a_z_correction_range,
    v_q[3] |-> ({1'b0, rem} < REM_LIMIT),
    "z division remainder out of the single-correction range")
  `D2P_ASSERT(a_z_in_range,
    out_valid_o |-> (pos_z_o <= Z_LIMIT),
    "z output above largest kept depth")
  `D2P_ASSERT_RST(a_reset_clears_output,
    !rst_ni |=> !out_valid_o,
    "output valid right after reset")

endmodule

[tb/depth_pixel_to_point_unit_test.sv]
// Self-checking testbench for depth_pixel_to_point_unit: pixel items in, 3D points out,
// compared with a built-in pinhole back-projection predictor. Depends on d2p_pkg and the RTL.
`timescale 1ns / 1ps

module depth_pixel_to_point_unit_test;

  localparam int unsigned DEPTH_FACTOR = 1000;
  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned DRAIN_CYCLES = 12;    // pipeline is 8 deep
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no handshake at all

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        pos_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  // DUT ports
  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [11:0]        row_i       = '0;
  logic [11:0]        col_i       = '0;
  logic [15:0]        depth_i     = '0;
  logic [7:0]         blue_i      = '0;
  logic [7:0]         green_i     = '0;
  logic [7:0]         red_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic [30:0]        pos_z_o;
  logic [7:0]         out_red_o;
  logic [7:0]         out_green_o;
  logic [7:0]         out_blue_o;

  // Shadow copy of the configuration
  logic [11:0] win_row_start;
  logic [12:0] win_row_end;
  logic [11:0] win_col_start;
  logic [12:0] win_col_end;
  logic [15:0] cam_center_x;
  logic [15:0] cam_center_y;
  logic [31:0] cam_inv_fx;
  logic [31:0] cam_inv_fy;

  point_t      expected_points[$];
  int unsigned mismatch_count = 0;
  bit          steady_flow    = 1'b0;  // no idling on either side while set

  depth_pixel_to_point_unit #(
    .DEPTH_FACTOR(DEPTH_FACTOR),
    .MAX_DIM     (MAX_DIM)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .row_i      (row_i),
    .col_i      (col_i),
    .depth_i    (depth_i),
    .blue_i     (blue_i),
    .green_i    (green_i),
    .red_i      (red_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // round(offset * z * inv / 2^36), ties away from zero, saturated to int32
  function automatic logic [31:0] backproject_axis(logic [11:0] pos, logic [15:0] center,
                                                   logic [31:0] inv, logic [30:0] z);
    longint          offset;
    bit              neg;
    longint unsigned mag, m, p_lo, p_hi, s, r;
    offset = longint'({pos, 4'b0000}) - longint'(center);
    neg    = offset < 0;
    mag    = neg ? longint'(-offset) : offset;
    m      = mag * longint'(z);
    p_lo   = m * longint'(inv[15:0]);
    p_hi   = m * longint'(inv[31:16]);
    s      = p_hi + (p_lo >> 16);
    r      = (s + (64'd1 << 19)) >> 20;
    if (neg) begin
      if (r >= (64'd1 << 31)) return 32'h8000_0000;
      return 32'(64'd0 - r);
    end
    if (r > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return r[31:0];
  endfunction

  // Returns 1 and the point when the pixel survives window and depth filters
  function automatic bit project_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] depth,
                                       logic [7:0] blue, logic [7:0] green, logic [7:0] red,
                                       output point_t pt);
    longint unsigned z;
    pt = '0;
    if (row < win_row_start || {1'b0, row} >= win_row_end) return 1'b0;
    if (col < win_col_start || {1'b0, col} >= win_col_end) return 1'b0;
    if (depth < d2p_pkg::DEPTH_MIN || depth >= d2p_pkg::DEPTH_MAX) return 1'b0;
    z = ((longint'(depth) << 16) + DEPTH_FACTOR / 2) / DEPTH_FACTOR;
    pt.pos_z = z[30:0];
    pt.pos_x = backproject_axis(col, cam_center_x, cam_inv_fx, pt.pos_z);
    pt.pos_y = backproject_axis(row, cam_center_y, cam_inv_fy, pt.pos_z);
    pt.red   = red;
    pt.green = green;
    pt.blue  = blue;
    return 1'b1;
  endfunction

  //--------------------------------------------------------------------------
  // Drivers
  //--------------------------------------------------------------------------

  // Send one pixel item; valid stays high on return
  task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] depth,
                            logic [7:0] blue, logic [7:0] green, logic [7:0] red);
    int unsigned gap;
    point_t      pt;
    gap = 0;
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 11) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i      <= row;
    col_i      <= col;
    depth_i    <= depth;
    blue_i     <= blue;
    green_i    <= green;
    red_i      <= red;
    do @(posedge clk_i); while (!in_ready_o);
    if (project_pixel(row, col, depth, blue, green, red, pt)) begin
      expected_points.insert(expected_points.size(), pt);
    end
  endtask

  // Pixel with random color bytes
  task automatic send_gray(logic [11:0] row, logic [11:0] col, logic [15:0] depth);
    send_pixel(row, col, depth, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stop sending and let every outstanding point drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays high on return
  task automatic write_register(d2p_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      d2p_pkg::CFG_ROW_START:   win_row_start = data[11:0];
      d2p_pkg::CFG_ROW_END:     win_row_end   = data[12:0];
      d2p_pkg::CFG_COL_START:   win_col_start = data[11:0];
      d2p_pkg::CFG_COL_END:     win_col_end   = data[12:0];
      d2p_pkg::CFG_CENTER_X:    cam_center_x  = data[15:0];
      d2p_pkg::CFG_CENTER_Y:    cam_center_y  = data[15:0];
      d2p_pkg::CFG_INV_FOCAL_X: cam_inv_fx    = data;
      d2p_pkg::CFG_INV_FOCAL_Y: cam_inv_fy    = data;
      default: ;
    endcase
  endtask

  // Rewrite the whole register set while the unit is idle
  task automatic program_camera(logic [31:0] row_start, logic [31:0] row_end,
                                logic [31:0] col_start, logic [31:0] col_end,
                                logic [31:0] center_x, logic [31:0] center_y,
                                logic [31:0] inv_fx, logic [31:0] inv_fy);
    wait_idle();
    write_register(d2p_pkg::CFG_ROW_START,   row_start);
    write_register(d2p_pkg::CFG_ROW_END,     row_end);
    write_register(d2p_pkg::CFG_COL_START,   col_start);
    write_register(d2p_pkg::CFG_COL_END,     col_end);
    write_register(d2p_pkg::CFG_CENTER_X,    center_x);
    write_register(d2p_pkg::CFG_CENTER_Y,    center_y);
    write_register(d2p_pkg::CFG_INV_FOCAL_X, inv_fx);
    write_register(d2p_pkg::CFG_INV_FOCAL_Y, inv_fy);
    cfg_valid_i <= 1'b0;
  endtask

  //--------------------------------------------------------------------------
  // Receiver and checker
  //--------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= 11);
  end

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : point_check
    point_t exp_pt;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point, expected none actual x=%h y=%h z=%h", $time,
                 pos_x_o, pos_y_o, pos_z_o);
        mismatch_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        check_field("pos_x", exp_pt.pos_x, pos_x_o);
        check_field("pos_y", exp_pt.pos_y, pos_y_o);
        check_field("pos_z", 32'(exp_pt.pos_z), 32'(pos_z_o));
        check_field("out_red", 32'(exp_pt.red), 32'(out_red_o));
        check_field("out_green", 32'(exp_pt.green), 32'(out_green_o));
        check_field("out_blue", 32'(exp_pt.blue), 32'(out_blue_o));
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("depth_pixel_to_point_unit verification failed");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Reset setup: principal point, depth limits, corners, color extremes
  task automatic test_default_setup();
    send_pixel(12'd240, 12'd320, 16'd1000, 8'h00, 8'h00, 8'h00);
    send_pixel(12'd0, 12'd0, 16'd100, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd4095, 12'd4095, 16'd2499, 8'h5A, 8'hA5, 8'h0F);
    send_gray(12'd100, 12'd200, 16'd99);
    send_gray(12'd100, 12'd200, 16'd2500);
    send_gray(12'd100, 12'd200, 16'd0);
    send_gray(12'd100, 12'd200, 16'hFFFF);
    send_gray(12'd1234, 12'd2345, 16'd1500);
  endtask

  // Inclusive start and exclusive end of the window, empty and inverted windows
  task automatic test_window_edges();
    program_camera(32'd10, 32'd20, 32'd30, 32'd40, 32'd5000, 32'd3700,
                   32'd7158278, 32'd7158278);
    send_gray(12'd9, 12'd35, 16'd500);
    send_gray(12'd10, 12'd35, 16'd500);
    send_gray(12'd19, 12'd35, 16'd500);
    send_gray(12'd20, 12'd35, 16'd500);
    send_gray(12'd15, 12'd29, 16'd500);
    send_gray(12'd15, 12'd30, 16'd500);
    send_gray(12'd15, 12'd39, 16'd500);
    send_gray(12'd15, 12'd40, 16'd500);
    // start equal to end
    program_camera(32'd50, 32'd50, 32'd0, 32'd4096, 32'd5000, 32'd3700,
                   32'd7158278, 32'd7158278);
    send_gray(12'd50, 12'd35, 16'd500);
    // start above end
    program_camera(32'd60, 32'd40, 32'd0, 32'd4096, 32'd5000, 32'd3700,
                   32'd7158278, 32'd7158278);
    send_gray(12'd50, 12'd35, 16'd500);
  endtask

  // All-ones writes (upper bits dropped), zero and full-scale reciprocals
  task automatic test_register_extremes();
    program_camera('1, '1, '1, '1, '1, '1, '1, '1);
    send_pixel(12'd4095, 12'd4095, 16'd2499, 8'hFF, 8'h00, 8'hFF);
    send_gray(12'd4094, 12'd4095, 16'd2499);
    program_camera(32'hFFFF_F000, 32'h0000_1000, 32'd0, 32'hFFFF_F000 | 32'd4096,
                   32'd0, 32'd0, 32'd0, 32'd0);
    send_gray(12'd4095, 12'd0, 16'd2499);
    program_camera(32'd0, 32'd4096, 32'd0, 32'd4096, 32'd0, 32'hFFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_gray(12'd0, 12'd4095, 16'd2499);
  endtask

  // Random or extreme camera setups per phase; mostly in-window pixels with valid depth
  task automatic test_random_phases();
    int unsigned fx, fy, rs, cs;
    logic [11:0] row, col, row_hi, col_hi;
    logic [15:0] depth;
    bit          open;
    for (int phase = 0; phase < 6; phase++) begin
      fx = $urandom_range(100, 2000);
      fy = $urandom_range(100, 2000);
      rs = $urandom_range(0, 4000);
      cs = $urandom_range(0, 4000);
      case (phase)
        1: program_camera(32'hFFFF_0000, '1, 32'h1234_5000, 32'h0000_1000,
                          32'd0, '1, '1, 32'd0);
        3: program_camera($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
        5: program_camera(32'd4095, 32'd4096, 32'd4000, 32'd4096,
                          32'hFFFF, 32'd0, 32'd0, '1);
        default: program_camera(rs, $urandom_range(rs + 1, 4096), cs,
                                $urandom_range(cs + 1, 4096),
                                32'({12'($urandom_range(0, 4095)), 4'($urandom)}),
                                32'({12'($urandom_range(0, 4095)), 4'($urandom)}),
                                32'((64'd1 << 32) / fx), 32'((64'd1 << 32) / fy));
      endcase
      steady_flow = (phase == 2);
      open = (win_row_start < win_row_end) && (win_col_start < win_col_end);
      row_hi = (win_row_end > MAX_DIM) ? 12'd4095 : 12'(win_row_end - 1);
      col_hi = (win_col_end > MAX_DIM) ? 12'd4095 : 12'(win_col_end - 1);
      for (int n = 0; n < 125; n++) begin
        if (open && $urandom_range(0, 99) < 75) begin
          row   = 12'($urandom_range(win_row_start, row_hi));
          col   = 12'($urandom_range(win_col_start, col_hi));
          depth = 16'($urandom_range(d2p_pkg::DEPTH_MIN, d2p_pkg::DEPTH_MAX - 1));
        end else begin
          row   = 12'($urandom);
          col   = 12'($urandom);
          depth = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2600));
        end
        send_gray(row, col, depth);
      end
      steady_flow = 1'b0;
    end
  endtask

  //--------------------------------------------------------------------------
  // Sequence
  //--------------------------------------------------------------------------

  initial begin
    // reset values of the unit
    win_row_start = '0;
    win_row_end   = 13'(MAX_DIM);
    win_col_start = '0;
    win_col_end   = 13'(MAX_DIM);
    cam_center_x  = 16'd5120;
    cam_center_y  = 16'd3840;
    cam_inv_fx    = 32'd8589934;
    cam_inv_fy    = 32'd8589934;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_setup();
    test_window_edges();
    test_register_extremes();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      $display("%0t: %0d points never arrived", $time, expected_points.size());
    end
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("depth_pixel_to_point_unit verification clean");
    end else begin
      $display("depth_pixel_to_point_unit verification failed");
    end
    $finish;
  end

endmodule
